/* hw/rtl/first_fit_extent_allocator_macros.svh */
// assertion macros for the extent allocator
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH

// property that holds on every clock edge outside reset
`define FFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// types and constants shared by the extent allocator modules
// ----------------------------------------------------------------------------
package ffa_pkg;
  localparam int unsigned MaxExtentsDefault = 16;
  localparam int unsigned AddrW = 32;
  localparam logic [AddrW-1:0] HdrBytes = 32'd4;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoMem    = 2'd1,
    StBadFree  = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef enum logic {
    ModeAlloc = 1'b0,
    ModeFree  = 1'b1
  } mode_e;

  typedef enum logic {
    RegHeapStart = 1'b0,
    RegHeapEnd   = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    FsIdle,
    FsScanRd,
    FsScanChk,
    FsShiftRd,
    FsShiftWr,
    FsInsShRd,
    FsInsShWr,
    FsInsPut,
    FsNxtRd,
    FsNxtChk,
    FsDone
  } fsm_e;

  // one entry of the extent table
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] len;
  } extent_t;
endpackage

/* hw/rtl/first_fit_extent_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// first-fit free extent table with split on allocate and merge on free
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// cmd      in         start_i / busy_o    mode, request_bytes, user_address, recorded_size
// result   out        done_o strobe       granted_address, status
// cfg      in         cfg_valid_i/ready_o cfg_index_i, cfg_data_i
//
// after the accept edge each extent read passes a read and a check state, since the
// table read is registered; each entry moved on a remove or insert passes a read and a
// write state; a free writes back and tries a merge; a done state gives the strobe.
// reset leaves the table empty; a config write reloads it with one extent (none if
// the heap end is not above its start) and holds busy for one cycle while it reloads.
// results last one cycle and cannot be stalled.
`include "first_fit_extent_allocator_macros.svh"

module first_fit_extent_allocator #(
  parameter int unsigned MaxExtents = ffa_pkg::MaxExtentsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] user_address_i,
  input  logic [31:0] recorded_size_i,
  output logic        done_o,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ffa_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxExtents);
  localparam int unsigned CntW = $clog2(MaxExtents + 1);

  logic [31:0] heap_start_q, heap_end_q, hs_d, he_d;
  logic        load_q, cfg_hit;
  logic        ctrl_busy;
  logic        we;
  logic [IdxW-1:0] waddr, raddr;
  extent_t     wdata, rdata;
  logic [CntW-1:0] count;

  // the table reload takes the cycle after a config write
  assign busy_o = ctrl_busy || load_q;

  // a start seen while idle wins over a config write
  assign cfg_ready_o = !busy_o && !load_q && !start_i;
  assign cfg_hit = cfg_valid_i && cfg_ready_o &&
                   (cfg_index_i == 32'(RegHeapStart) || cfg_index_i == 32'(RegHeapEnd));
  assign hs_d = (cfg_hit && cfg_index_i == 32'(RegHeapStart)) ? cfg_data_i : heap_start_q;
  assign he_d = (cfg_hit && cfg_index_i == 32'(RegHeapEnd)) ? cfg_data_i : heap_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q <= '0;
      heap_end_q   <= '0;
      load_q       <= 1'b0;
    end else begin
      heap_start_q <= hs_d;
      heap_end_q   <= he_d;
      load_q       <= cfg_hit;
    end
  end

  ffa_ctrl #(.MaxExtents(MaxExtents)) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i         (start_i && !load_q),
    .busy_o          (ctrl_busy),
    .mode_i,
    .request_bytes_i,
    .user_address_i,
    .recorded_size_i,
    .load_i          (load_q),
    .load_base_i     (heap_start_q),
    .load_len_i      (heap_end_q - heap_start_q),
    .load_nonempty_i (heap_end_q > heap_start_q),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .raddr_o         (raddr),
    .rdata_i         (rdata),
    .done_o,
    .granted_address_o,
    .status_o,
    .count_o         (count)
  );

  ffa_ram #(.Width($bits(extent_t)), .Depth(MaxExtents)) u_table (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  `FFA_ASSERT(a_count_range, count <= CntW'(MaxExtents), "extent count over table size")
  `FFA_ASSERT_NEXT(a_done_ends, done_o, !busy_o, "busy after result")
  `FFA_ASSERT(a_grant_fail_zero, !done_o || status_o == StOk || granted_address_o == '0,
              "nonzero grant on failure")
endmodule

/* hw/rtl/ffa_ram.sv */
// ----------------------------------------------------------------------------
// ffa_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/ffa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffa_ctrl
// sequencer: scans the sorted table, splits, shifts and merges extents
// ----------------------------------------------------------------------------
module ffa_ctrl #(
  parameter int unsigned MaxExtents = ffa_pkg::MaxExtentsDefault,
  localparam int unsigned IdxW = $clog2(MaxExtents),
  localparam int unsigned CntW = $clog2(MaxExtents + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   mode_i,
  input  logic [31:0]            request_bytes_i,
  input  logic [31:0]            user_address_i,
  input  logic [31:0]            recorded_size_i,
  input  logic                   load_i,
  input  logic [31:0]            load_base_i,
  input  logic [31:0]            load_len_i,
  input  logic                   load_nonempty_i,
  output logic                   we_o,
  output logic [IdxW-1:0]        waddr_o,
  output ffa_pkg::extent_t       wdata_o,
  output logic [IdxW-1:0]        raddr_o,
  input  ffa_pkg::extent_t       rdata_i,
  output logic                   done_o,
  output logic [31:0]            granted_address_o,
  output logic [1:0]             status_o,
  output logic [CntW-1:0]        count_o
);
  import ffa_pkg::*;

  fsm_e            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            mode_q, mode_d;
  logic [31:0]     need_q, need_d;
  logic [31:0]     block_q, block_d;
  logic [32:0]     bend_q, bend_d;
  logic            prev_ok_q, prev_ok_d;
  extent_t         prev_q, prev_d;
  extent_t         cur_q, cur_d;
  logic [31:0]     grant_q, grant_d;
  logic [1:0]      status_q, status_d;

  logic [32:0] need33, size33, prev_end, cur_end;

  assign need33   = {1'b0, request_bytes_i} + {1'b0, HdrBytes};
  assign size33   = {1'b0, recorded_size_i} + {1'b0, HdrBytes};
  assign prev_end = {1'b0, prev_q.base} + {1'b0, prev_q.len};
  assign cur_end  = {1'b0, cur_q.base} + {1'b0, cur_q.len};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    mode_q    <= mode_d;
    need_q    <= need_d;
    block_q   <= block_d;
    bend_q    <= bend_d;
    prev_ok_q <= prev_ok_d;
    prev_q    <= prev_d;
    cur_q     <= cur_d;
    grant_q   <= grant_d;
    status_q  <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    mode_d    = mode_q;
    need_d    = need_q;
    block_d   = block_q;
    bend_d    = bend_q;
    prev_ok_d = prev_ok_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    grant_d   = grant_q;
    status_d  = status_q;
    we_o      = 1'b0;
    waddr_o   = idx_q[IdxW-1:0];
    wdata_o   = cur_q;
    raddr_o   = idx_q[IdxW-1:0];
    done_o    = 1'b0;

    case (state_q)
      FsIdle: begin
        if (load_i) begin
          we_o    = 1'b1;
          waddr_o = '0;
          wdata_o = '{base: load_base_i, len: load_len_i};
          count_d = load_nonempty_i ? CntW'(1) : '0;
        end else if (start_i) begin
          mode_d    = mode_i;
          idx_d     = '0;
          prev_ok_d = 1'b0;
          grant_d   = '0;
          need_d    = need33[31:0];
          block_d   = user_address_i - HdrBytes;
          bend_d    = {1'b0, user_address_i - HdrBytes} + size33;
          raddr_o   = '0;
          if (mode_i == ModeAlloc) begin
            if (need33[32]) begin
              status_d = StNoMem;
              state_d  = FsDone;
            end else begin
              state_d = FsScanRd;
            end
          end else begin
            need_d = size33[31:0];
            if (size33[32] || ({1'b0, user_address_i - HdrBytes} + size33) > 33'hFFFFFFFF)
            begin
              status_d = StBadFree;
              state_d  = FsDone;
            end else begin
              state_d = FsScanRd;
            end
          end
        end
      end
      // read entry idx; data arrives next cycle
      FsScanRd: begin
        if (idx_q >= count_q) begin
          if (mode_q == ModeAlloc) begin
            status_d = StNoMem;
            state_d  = FsDone;
          end else begin
            // no next extent
            if (prev_ok_q && prev_end > {1'b0, block_q}) begin
              status_d = StBadFree;
              state_d  = FsDone;
            end else if (prev_ok_q && prev_end == {1'b0, block_q}) begin
              cur_d    = '{base: prev_q.base, len: prev_q.len + need_q};
              idx_d    = idx_q - CntW'(1);
              status_d = StOk;
              state_d  = FsInsPut;
            end else if (count_q >= CntW'(MaxExtents)) begin
              status_d = StFull;
              state_d  = FsDone;
            end else begin
              cur_d    = '{base: block_q, len: need_q};
              count_d  = count_q + CntW'(1);
              status_d = StOk;
              state_d  = FsInsPut;
            end
          end
        end else begin
          state_d = FsScanChk;
        end
      end
      FsScanChk: begin
        cur_d = rdata_i;
        if (mode_q == ModeAlloc) begin
          if (rdata_i.len >= need_q) begin
            grant_d  = rdata_i.base + HdrBytes;
            status_d = StOk;
            if (rdata_i.len == need_q) begin
              state_d = FsShiftRd;
            end else begin
              we_o    = 1'b1;
              wdata_o = '{base: rdata_i.base + need_q, len: rdata_i.len - need_q};
              state_d = FsDone;
            end
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = FsScanRd;
          end
        end else begin
          if (rdata_i.base < block_q) begin
            prev_d    = rdata_i;
            prev_ok_d = 1'b1;
            idx_d     = idx_q + CntW'(1);
            state_d   = FsScanRd;
          end else if ((prev_ok_q && prev_end > {1'b0, block_q}) ||
                       bend_q > {1'b0, rdata_i.base}) begin
            status_d = StBadFree;
            state_d  = FsDone;
          end else if (prev_ok_q && prev_end == {1'b0, block_q}) begin
            // grow previous, then try to absorb entry idx
            cur_d    = '{base: prev_q.base, len: prev_q.len + need_q};
            idx_d    = idx_q - CntW'(1);
            status_d = StOk;
            state_d  = FsNxtRd;
          end else if (bend_q == {1'b0, rdata_i.base}) begin
            we_o     = 1'b1;
            wdata_o  = '{base: block_q, len: rdata_i.len + need_q};
            status_d = StOk;
            state_d  = FsDone;
          end else if (count_q >= CntW'(MaxExtents)) begin
            status_d = StFull;
            state_d  = FsDone;
          end else begin
            // shift entries idx..count-1 up by one, from the top
            prev_d   = '{base: block_q, len: need_q};
            block_d  = 32'(idx_q);
            idx_d    = count_q;
            status_d = StOk;
            state_d  = FsInsShRd;
          end
        end
      end
      // remove entry idx by moving the tail down
      FsShiftRd: begin
        if (idx_q + CntW'(1) >= count_q) begin
          count_d = count_q - CntW'(1);
          state_d = FsDone;
        end else begin
          raddr_o = IdxW'(idx_q + CntW'(1));
          state_d = FsShiftWr;
        end
      end
      FsShiftWr: begin
        we_o    = 1'b1;
        wdata_o = rdata_i;
        idx_d   = idx_q + CntW'(1);
        state_d = FsShiftRd;
      end
      FsInsShRd: begin
        if (idx_q <= CntW'(block_q)) begin
          cur_d   = prev_q;
          count_d = count_q + CntW'(1);
          state_d = FsInsPut;
        end else begin
          raddr_o = IdxW'(idx_q - CntW'(1));
          state_d = FsInsShWr;
        end
      end
      FsInsShWr: begin
        we_o    = 1'b1;
        wdata_o = rdata_i;
        idx_d   = idx_q - CntW'(1);
        state_d = FsInsShRd;
      end
      // write cur at idx, then look at idx+1 for a merge
      FsInsPut: begin
        we_o    = 1'b1;
        wdata_o = cur_q;
        state_d = FsNxtRd;
      end
      FsNxtRd: begin
        if (idx_q + CntW'(1) >= count_q) begin
          if (mode_q == ModeFree) begin
            we_o = 1'b1;
          end
          state_d = FsDone;
        end else begin
          raddr_o = IdxW'(idx_q + CntW'(1));
          state_d = FsNxtChk;
        end
      end
      FsNxtChk: begin
        if (cur_end == {1'b0, rdata_i.base}) begin
          cur_d   = '{base: cur_q.base, len: cur_q.len + rdata_i.len};
          we_o    = 1'b1;
          wdata_o = '{base: cur_q.base, len: cur_q.len + rdata_i.len};
          idx_d   = idx_q + CntW'(1);
          state_d = FsShiftRd;
        end else begin
          we_o    = 1'b1;
          state_d = FsDone;
        end
      end
      FsDone: begin
        done_o  = 1'b1;
        state_d = FsIdle;
      end
      default: state_d = FsIdle;
    endcase
  end

  assign busy_o            = (state_q != FsIdle);
  assign granted_address_o = grant_q;
  assign status_o          = status_q;
  assign count_o           = count_q;
endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks the first-fit extent allocator against a cycle-free predictor of the
// free extent table: directed corner cases, a table-full fill, then random alloc/free
// traffic over several heap settings, with random gaps on the command side
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int unsigned MaxExt = 16;
  localparam int unsigned CycleLimit = 3000000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        mode_i;
  logic [31:0] request_bytes_i;
  logic [31:0] user_address_i;
  logic [31:0] recorded_size_i;
  logic        done_o;
  logic [31:0] granted_address_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  first_fit_extent_allocator dut (.*);

  typedef struct packed {
    logic [31:0] addr;
    status_e     st;
  } grant_t;

  // predictor state
  logic [31:0] heap_lo, heap_hi;
  logic [31:0] ext_base [MaxExt];
  logic [31:0] ext_len  [MaxExt];
  int unsigned ext_cnt;

  grant_t      pending_grants [$];
  logic [31:0] live_addr [$];
  logic [31:0] live_size [$];
  int unsigned n_errors, n_checked, n_sent, n_alloc_ok, n_free_ok, n_full;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(input string what);
    n_errors++;
    $display("mismatch %0d: %s", n_errors, what);
  endtask

  always @(posedge clk_i) begin
    grant_t exp;
    if (rst_ni && done_o) begin
      if (pending_grants.size() == 0) begin
        report($sformatf("unexpected result addr=%h st=%0d", granted_address_o, status_o));
      end else begin
        exp = pending_grants.pop_front();
        n_checked++;
        if (granted_address_o !== exp.addr)
          report($sformatf("granted_address got %h want %h", granted_address_o, exp.addr));
        if (status_o !== exp.st)
          report($sformatf("status got %0d want %0d", status_o, exp.st));
      end
    end
  end

  function automatic void load_heap();
    if (heap_hi > heap_lo) begin
      ext_base[0] = heap_lo;
      ext_len[0]  = heap_hi - heap_lo;
      ext_cnt = 1;
    end else begin
      ext_cnt = 0;
    end
  endfunction

  function automatic void drop_extent(int unsigned i);
    for (int unsigned k = i; k + 1 < ext_cnt; k++) begin
      ext_base[k] = ext_base[k+1];
      ext_len[k]  = ext_len[k+1];
    end
    ext_cnt--;
  endfunction

  function automatic grant_t predict_alloc(logic [31:0] req);
    logic [32:0] need;
    grant_t g;
    g.addr = '0;
    g.st   = StNoMem;
    need = {1'b0, req} + 33'd4;
    if (need[32]) return g;
    for (int unsigned i = 0; i < ext_cnt; i++) begin
      if (ext_len[i] >= need[31:0]) begin
        g.addr = ext_base[i] + 32'd4;
        g.st = StOk;
        if (ext_len[i] == need[31:0]) drop_extent(i);
        else begin
          ext_base[i] = ext_base[i] + need[31:0];
          ext_len[i]  = ext_len[i] - need[31:0];
        end
        return g;
      end
    end
    return g;
  endfunction

  function automatic status_e predict_free(logic [31:0] ua, logic [31:0] rs);
    logic [32:0] sz, bend, pend;
    logic [31:0] blk;
    int unsigned i, cur;
    bit has_prev, has_next;
    sz = {1'b0, rs} + 33'd4;
    blk = ua - 32'd4;
    if (sz[32]) return StBadFree;
    bend = {1'b0, blk} + sz;
    if (bend[32]) return StBadFree;
    i = 0;
    while (i < ext_cnt && ext_base[i] < blk) i++;
    has_prev = i > 0;
    has_next = i < ext_cnt;
    pend = has_prev ? {1'b0, ext_base[i-1]} + {1'b0, ext_len[i-1]} : '0;
    if (has_prev && pend > {1'b0, blk}) return StBadFree;
    if (has_next && bend > {1'b0, ext_base[i]}) return StBadFree;
    if (has_prev && pend == {1'b0, blk}) begin
      cur = i - 1;
      ext_len[cur] = ext_len[cur] + sz[31:0];
    end else if (has_next && bend == {1'b0, ext_base[i]}) begin
      ext_base[i] = blk;
      ext_len[i]  = ext_len[i] + sz[31:0];
      return StOk;
    end else begin
      if (ext_cnt >= MaxExt) return StFull;
      for (int unsigned k = ext_cnt; k > i; k--) begin
        ext_base[k] = ext_base[k-1];
        ext_len[k]  = ext_len[k-1];
      end
      ext_base[i] = blk;
      ext_len[i]  = sz[31:0];
      ext_cnt++;
      cur = i;
    end
    if (cur + 1 < ext_cnt &&
        {1'b0, ext_base[cur]} + {1'b0, ext_len[cur]} == {1'b0, ext_base[cur+1]}) begin
      ext_len[cur] = ext_len[cur] + ext_len[cur+1];
      drop_extent(cur + 1);
    end
    return StOk;
  endfunction

  task automatic idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clk_i);
  endtask

  // sends one item at the falling edge and waits for its acceptance
  task automatic send_item(mode_e m, logic [31:0] req, logic [31:0] ua, logic [31:0] rs);
    grant_t g;
    start_i = 1'b1;
    mode_i = m;
    request_bytes_i = req;
    user_address_i = ua;
    recorded_size_i = rs;
    do @(posedge clk_i); while (busy_o);
    if (m == ModeAlloc) begin
      g = predict_alloc(req);
      if (g.st == StOk) begin
        n_alloc_ok++;
        live_addr.push_back(g.addr);
        live_size.push_back(req);
      end
    end else begin
      g.addr = '0;
      g.st = predict_free(ua, rs);
      if (g.st == StOk) n_free_ok++;
      if (g.st == StFull) n_full++;
    end
    pending_grants.push_back(g);
    n_sent++;
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_grants.size() != 0) @(negedge clk_i);
    // a free item returns one result, so a short margin covers the tail
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = 32'(idx);
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegHeapStart) heap_lo = data;
    else heap_hi = data;
    load_heap();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_heap(logic [31:0] lo, logic [31:0] hi);
    drain();
    write_reg(RegHeapStart, lo);
    write_reg(RegHeapEnd, hi);
    live_addr.delete();
    live_size.delete();
  endtask

  task automatic test_directed();
    // empty heap: every allocate fails
    set_heap(32'h1000, 32'h1000);
    send_item(ModeAlloc, 32'd0, '0, '0);
    // unknown register index is ignored
    cfg_valid_i = 1'b1;
    cfg_index_i = 32'd7;
    cfg_data_i = 32'hFFFF_FFFF;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    send_item(ModeAlloc, 32'd4, '0, '0);
    set_heap(32'h0000_1000, 32'h0000_1100);
    send_item(ModeAlloc, 32'hFFFF_FFFC, '0, '0);   // request overflow
    send_item(ModeAlloc, 32'hFFFF_FFFF, '0, '0);
    send_item(ModeAlloc, 32'd12, '0, '0);
    send_item(ModeAlloc, 32'd0, '0, '0);
    send_item(ModeAlloc, 32'd28, '0, '0);
    send_item(ModeFree, '0, 32'h0000_1004, 32'hFFFF_FFFC);  // size overflow
    send_item(ModeFree, '0, 32'h0000_0000, 32'd8);          // block wraps past top
    send_item(ModeFree, '0, 32'hFFFF_FFF8, 32'd8);          // ends past address top
    send_item(ModeFree, '0, 32'h0000_1004, 32'd16);         // oversized, added as a separate extent
    send_item(ModeFree, '0, 32'h0000_1014, 32'd0);          // overlaps previous extent
    send_item(ModeFree, '0, 32'h0000_1004, 32'd12);         // overlaps next extent
    send_item(ModeFree, '0, 32'h0000_1018, 32'd28);         // joins both
    send_item(ModeAlloc, 32'd251, '0, '0);
    send_item(ModeAlloc, 32'd252, '0, '0);                  // fails: one byte left in the heap
    // full address range heap
    set_heap(32'h0000_0000, 32'hFFFF_FFFF);
    send_item(ModeAlloc, 32'hFFFF_FFFA, '0, '0);
    send_item(ModeFree, '0, 32'h0000_0004, 32'hFFFF_FFFA);
    send_item(ModeFree, '0, 32'h8000_0000, 32'h0);          // overlaps previous
  endtask

  // fills the table with scattered single frees to reach the full case
  task automatic test_table_full();
    set_heap(32'h0002_0000, 32'h0002_0000 + 32'd2048);
    for (int i = 0; i < 60; i++) send_item(ModeAlloc, 32'd28, '0, '0);
    // wait for every result, then free every other one of the first forty blocks
    drain();
    for (int i = 0; i < 40; i += 2)
      send_item(ModeFree, '0, 32'h0002_0004 + 32'(i * 32), 32'd28);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned r, k;
    logic [31:0] lo, span;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 400 == 0) begin
        r = $urandom_range(0, 3);
        lo = (r == 0) ? 32'h0 : $urandom() & 32'hFFFF_FFF0;
        span = (r == 1) ? 32'hFFFF_FFFF - lo : 32'($urandom_range(64, 4096));
        if (r == 3) span = 32'd0;
        if ({1'b0, lo} + {1'b0, span} > 33'hFFFF_FFFF) span = 32'hFFFF_FFFF - lo;
        set_heap(lo, lo + span);
      end
      if (n == count / 2) drain();
      idle_gap();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_item(ModeAlloc, $urandom_range(0, 9) == 0 ? $urandom() :
                  32'($urandom_range(0, 200)), '0, '0);
      end else if (r < 85 && live_addr.size() != 0) begin
        k = $urandom_range(0, live_addr.size() - 1);
        send_item(ModeFree, '0, live_addr[k], live_size[k]);
        live_addr.delete(k);
        live_size.delete(k);
      end else begin
        // noise: wild or slightly off frees
        send_item(ModeFree, '0, $urandom(), $urandom_range(0, 3) == 0 ? $urandom() :
                  32'($urandom_range(0, 64)));
      end
    end
  endtask

  initial begin
    n_errors = 0; n_checked = 0; n_sent = 0; cycles = 0;
    n_alloc_ok = 0; n_free_ok = 0; n_full = 0;
    heap_lo = '0; heap_hi = '0; ext_cnt = 0;
    start_i = 1'b0; mode_i = 1'b0;
    request_bytes_i = '0; user_address_i = '0; recorded_size_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    test_random(1850);
    drain();
    $display("sent %0d items, checked %0d results over several heap settings", n_sent, n_checked);
    $display("grants %0d, good frees %0d, table full %0d", n_alloc_ok, n_free_ok, n_full);
    if (n_errors == 0 && pending_grants.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
